@@ src/assert_macros.svh @@
// ---------------------------------------------------------------------------
// assert_macros.svh - assertion helpers
// Short wrappers around concurrent assertions clocked on clk, reset by rst_n.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// condition a implies b in the same cycle
`define BTS_ASSERT_IMP(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
    else $error("bts assertion failed");
// condition a implies b in the next cycle
`define BTS_ASSERT_NXT(lbl, a, b) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
    else $error("bts assertion failed");
`else
`define BTS_ASSERT_IMP(lbl, a, b)
`define BTS_ASSERT_NXT(lbl, a, b)
`endif

`endif

@@ src/bts_pkg.sv @@
// ---------------------------------------------------------------------------
// bts_pkg - shared definitions of the bilinear texture sampler
// Field widths, register codes, queue sizing and status types.
// ---------------------------------------------------------------------------
`default_nettype none

package bts_pkg;

  // fixed field widths
  localparam int STORE_AW    = 16;
  localparam int STORE_DEPTH = 1 << STORE_AW;
  localparam int TEXEL_W     = 24;
  localparam int CH_W        = 8;
  localparam int NUM_CH      = 3;
  localparam int COORD_W     = 16;
  localparam int BRIGHT_W    = 17;
  localparam int BRIGHT_FRAC = 16;
  localparam int DIM_REG_W   = 9;
  localparam int IN_TDATA_W  = 96;
  localparam int OUT_TDATA_W = 24;
  localparam int NUM_BANKS   = 4;

  // parameter defaults
  localparam int MAX_TEX_WIDTH_DEF   = 256;
  localparam int MAX_TEX_HEIGHT_DEF  = 256;
  localparam int COORD_FRAC_BITS_DEF = 16;

  // configuration port
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic [DIM_REG_W-1:0] DIM_RESET = 9'd256;
  localparam logic REG_TEX_WIDTH  = 1'b0;
  localparam logic REG_TEX_HEIGHT = 1'b1;

  // item kinds
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // queue between front and back
  localparam int QUEUE_DEPTH = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } bts_q_stat_t;

  // queue entry: kind, four addresses, texel, two fractions, brightness
  function automatic int q_width(input int frac_bits);
    return 1 + NUM_BANKS * STORE_AW + TEXEL_W + 2 * frac_bits + BRIGHT_W;
  endfunction

endpackage

`default_nettype wire

@@ src/bts_front.sv @@
// ---------------------------------------------------------------------------
// bts_front - item intake and coordinate setup
// Accepts items, splits sample coordinates into clamped texel indices and
// fractions, forms the four store addresses and pushes to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module bts_front #(
  parameter int MAX_TEX_WIDTH   = bts_pkg::MAX_TEX_WIDTH_DEF,
  parameter int MAX_TEX_HEIGHT  = bts_pkg::MAX_TEX_HEIGHT_DEF,
  parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                                        clk,
  input  wire                                        rst_n,
  input  wire                                        in_tvalid,
  output logic                                       in_tready,
  input  wire  [0:0]                                 in_tuser,
  input  wire  [bts_pkg::IN_TDATA_W-1:0]             in_tdata,
  input  wire  [bts_pkg::DIM_REG_W-1:0]              tex_width,
  input  wire  [bts_pkg::DIM_REG_W-1:0]              tex_height,
  input  wire                                        q_full,
  output logic                                       push_valid,
  output logic [bts_pkg::q_width(COORD_FRAC_BITS)-1:0] push_data
);
  import bts_pkg::*;

  localparam int F   = COORD_FRAC_BITS;
  localparam int DW  = $clog2(MAX_TEX_WIDTH + 1);
  localparam int DHW = $clog2(MAX_TEX_HEIGHT + 1);
  localparam int IXW = $clog2(MAX_TEX_WIDTH);
  localparam int IYW = $clog2(MAX_TEX_HEIGHT);
  localparam int CWW = (DW > DIM_REG_W) ? DW : DIM_REG_W;
  localparam int CHW = (DHW > DIM_REG_W) ? DHW : DIM_REG_W;
  localparam int XW  = ((COORD_W > F) ? COORD_W : F) + DW;
  localparam int YW  = ((COORD_W > F) ? COORD_W : F) + DHW;

  // effective texture size
  logic [DW-1:0]  eff_w;
  logic [DHW-1:0] eff_h;

  always_comb begin
    if (tex_width == '0) begin
      eff_w = DW'(1);
    end else if (CWW'(tex_width) > CWW'(MAX_TEX_WIDTH)) begin
      eff_w = DW'(MAX_TEX_WIDTH);
    end else begin
      eff_w = DW'(tex_width);
    end
    if (tex_height == '0) begin
      eff_h = DHW'(1);
    end else if (CHW'(tex_height) > CHW'(MAX_TEX_HEIGHT)) begin
      eff_h = DHW'(MAX_TEX_HEIGHT);
    end else begin
      eff_h = DHW'(tex_height);
    end
  end

  // unpack the input item
  logic [STORE_AW-1:0] in_addr;
  logic [TEXEL_W-1:0]  in_texel;
  logic [COORD_W-1:0]  in_u;
  logic [COORD_W-1:0]  in_v;
  logic [BRIGHT_W-1:0] in_bright;

  assign in_addr   = in_tdata[15:0];
  assign in_texel  = {in_tdata[23:16], in_tdata[31:24], in_tdata[39:32]};
  assign in_u      = in_tdata[55:40];
  assign in_v      = in_tdata[71:56];
  assign in_bright = in_tdata[88:72];

  // scale coordinates and clamp at one
  logic [XW-1:0]  x_scaled;
  logic [XW-1:0]  x_int;
  logic [YW-1:0]  y_scaled;
  logic [YW-1:0]  y_int;
  logic [IXW-1:0] ix;
  logic [IYW-1:0] iy;
  logic [F-1:0]   fx;
  logic [F-1:0]   fy;

  always_comb begin
    x_scaled = XW'(in_u) * XW'(eff_w);
    x_int    = x_scaled >> F;
    if (x_int >= XW'(eff_w)) begin
      ix = IXW'(eff_w - DW'(1));
      fx = '0;
    end else begin
      ix = x_int[IXW-1:0];
      fx = x_scaled[F-1:0];
    end
    y_scaled = YW'(in_v) * YW'(eff_h);
    y_int    = y_scaled >> F;
    if (y_int >= YW'(eff_h)) begin
      iy = IYW'(eff_h - DHW'(1));
      fy = '0;
    end else begin
      iy = y_int[IYW-1:0];
      fy = y_scaled[F-1:0];
    end
  end

  // setup register
  logic                f1_valid_r;
  logic                f1_sample_r;
  logic [STORE_AW-1:0] f1_addr_r;
  logic [TEXEL_W-1:0]  f1_texel_r;
  logic [IXW-1:0]      f1_ix_r;
  logic [IYW-1:0]      f1_iy_r;
  logic [F-1:0]        f1_fx_r;
  logic [F-1:0]        f1_fy_r;
  logic [BRIGHT_W-1:0] f1_bright_r;
  logic                accept;

  assign in_tready = !f1_valid_r || !q_full;
  assign accept    = in_tvalid && in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (accept) begin
      f1_valid_r <= 1'b1;
    end else if (!q_full) begin
      f1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      f1_sample_r <= (in_tuser[0] == OP_SAMPLE);
      f1_addr_r   <= in_addr;
      f1_texel_r  <= in_texel;
      f1_ix_r     <= ix;
      f1_iy_r     <= iy;
      f1_fx_r     <= fx;
      f1_fy_r     <= fy;
      f1_bright_r <= in_bright;
    end
  end

  // neighbors with edge clamp and store addresses
  logic [IXW-1:0]      ix1;
  logic [IYW-1:0]      iy1;
  logic [STORE_AW-1:0] row0;
  logic [STORE_AW-1:0] row1;
  logic [STORE_AW-1:0] addr_a;
  logic [STORE_AW-1:0] addr_b;
  logic [STORE_AW-1:0] addr_c;
  logic [STORE_AW-1:0] addr_d;

  always_comb begin
    if ((DW+1)'(f1_ix_r) + (DW+1)'(1) < (DW+1)'(eff_w)) begin
      ix1 = f1_ix_r + IXW'(1);
    end else begin
      ix1 = f1_ix_r;
    end
    if ((DHW+1)'(f1_iy_r) + (DHW+1)'(1) < (DHW+1)'(eff_h)) begin
      iy1 = f1_iy_r + IYW'(1);
    end else begin
      iy1 = f1_iy_r;
    end
    row0 = STORE_AW'((IYW+DW)'(f1_iy_r) * (IYW+DW)'(eff_w));
    row1 = STORE_AW'((IYW+DW)'(iy1) * (IYW+DW)'(eff_w));
    if (f1_sample_r) begin
      addr_a = row0 + STORE_AW'(f1_ix_r);
    end else begin
      addr_a = f1_addr_r;
    end
    addr_b = row0 + STORE_AW'(ix1);
    addr_c = row1 + STORE_AW'(f1_ix_r);
    addr_d = row1 + STORE_AW'(ix1);
  end

  assign push_valid = f1_valid_r;
  assign push_data  = {f1_sample_r, addr_a, addr_b, addr_c, addr_d, f1_texel_r,
                       f1_fx_r, f1_fy_r, f1_bright_r};

endmodule

`default_nettype wire

@@ src/bts_queue.sv @@
// ---------------------------------------------------------------------------
// bts_queue - short queue between front and back
// Small first-in first-out buffer so either side can stall on its own.
// ---------------------------------------------------------------------------
`default_nettype none

module bts_queue #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = bts_pkg::QUEUE_DEPTH
) (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       push,
  input  wire  [DATA_W-1:0]         push_data,
  input  wire                       pop,
  output logic                      pop_valid,
  output logic [DATA_W-1:0]         pop_data,
  output bts_pkg::bts_q_stat_t      stat
);
  import bts_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] q_mem [DEPTH];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [CW-1:0]     count_r;
  logic              do_push;
  logic              do_pop;

  assign stat.full  = (count_r == CW'(DEPTH));
  assign stat.empty = (count_r == '0);
  assign pop_valid  = !stat.empty;
  assign pop_data   = q_mem[rd_ptr_r];
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      q_mem[wr_ptr_r] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

@@ src/bts_back.sv @@
// ---------------------------------------------------------------------------
// bts_back - texel store and filter pipeline
// Four replicated store banks give the four neighbor reads in the same cycle;
// then horizontal blend, vertical blend, brightness scale and saturation.
// ---------------------------------------------------------------------------
`default_nettype none

module bts_back #(
  parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                                          clk,
  input  wire                                          rst_n,
  input  wire                                          q_valid,
  input  wire  [bts_pkg::q_width(COORD_FRAC_BITS)-1:0] q_data,
  output logic                                         q_pop,
  output logic                                         out_tvalid,
  input  wire                                          out_tready,
  output logic [bts_pkg::OUT_TDATA_W-1:0]              out_tdata
);
  import bts_pkg::*;

  localparam int F  = COORD_FRAC_BITS;
  localparam int TW = CH_W + F;
  localparam int SW = CH_W + 2 * F;
  localparam int PW = TW + BRIGHT_W;
  localparam int RW = PW - F - BRIGHT_FRAC;

  // unpack queue entry
  logic                          e_sample;
  logic [NUM_BANKS-1:0][STORE_AW-1:0] e_addr;
  logic [TEXEL_W-1:0]            e_texel;
  logic [F-1:0]                  e_fx;
  logic [F-1:0]                  e_fy;
  logic [BRIGHT_W-1:0]           e_bright;

  assign {e_sample, e_addr[0], e_addr[1], e_addr[2], e_addr[3], e_texel,
          e_fx, e_fy, e_bright} = q_data;

  // pipeline advance
  logic en;
  logic out_valid_r;

  assign en    = !out_valid_r || out_tready;
  assign q_pop = en && q_valid;

  // texel store banks, each holding a full copy
  logic [TEXEL_W-1:0] b1_texel_r [NUM_BANKS];

  for (genvar bank = 0; bank < NUM_BANKS; bank++) begin : g_bank
    logic [TEXEL_W-1:0] mem [STORE_DEPTH];

    always_ff @(posedge clk) begin
      if (q_pop && !e_sample) begin
        mem[e_addr[0]] <= e_texel;
      end
      if (en) begin
        b1_texel_r[bank] <= mem[e_addr[bank]];
      end
    end
  end

  // stage 1 side fields
  logic                b1_valid_r;
  logic [F-1:0]        b1_fx_r;
  logic [F-1:0]        b1_fy_r;
  logic [BRIGHT_W-1:0] b1_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b1_valid_r <= 1'b0;
    end else if (en) begin
      b1_valid_r <= q_pop && e_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b1_fx_r     <= e_fx;
      b1_fy_r     <= e_fy;
      b1_bright_r <= e_bright;
    end
  end

  // horizontal blend of top and bottom rows
  logic [F:0]            wx0;
  logic [NUM_CH-1:0][TW-1:0] top_nxt;
  logic [NUM_CH-1:0][TW-1:0] bot_nxt;

  always_comb begin
    wx0 = (F+1)'(1 << F) - (F+1)'(b1_fx_r);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      top_nxt[ch] = TW'(b1_texel_r[0][TEXEL_W-1-CH_W*ch -: CH_W]) * TW'(wx0)
                  + TW'(b1_texel_r[1][TEXEL_W-1-CH_W*ch -: CH_W]) * TW'(b1_fx_r);
      bot_nxt[ch] = TW'(b1_texel_r[2][TEXEL_W-1-CH_W*ch -: CH_W]) * TW'(wx0)
                  + TW'(b1_texel_r[3][TEXEL_W-1-CH_W*ch -: CH_W]) * TW'(b1_fx_r);
    end
  end

  logic                      b2_valid_r;
  logic [NUM_CH-1:0][TW-1:0] b2_top_r;
  logic [NUM_CH-1:0][TW-1:0] b2_bot_r;
  logic [F-1:0]              b2_fy_r;
  logic [BRIGHT_W-1:0]       b2_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b2_valid_r <= 1'b0;
    end else if (en) begin
      b2_valid_r <= b1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b2_top_r    <= top_nxt;
      b2_bot_r    <= bot_nxt;
      b2_fy_r     <= b1_fy_r;
      b2_bright_r <= b1_bright_r;
    end
  end

  // vertical blend and truncation to the filtered value
  logic [F:0]                wy0;
  logic [NUM_CH-1:0][SW-1:0] vsum;
  logic [NUM_CH-1:0][TW-1:0] filt_nxt;

  always_comb begin
    wy0 = (F+1)'(1 << F) - (F+1)'(b2_fy_r);
    for (int ch = 0; ch < NUM_CH; ch++) begin
      vsum[ch]     = SW'(b2_top_r[ch]) * SW'(wy0) + SW'(b2_bot_r[ch]) * SW'(b2_fy_r);
      filt_nxt[ch] = TW'(vsum[ch] >> F);
    end
  end

  logic                      b3_valid_r;
  logic [NUM_CH-1:0][TW-1:0] b3_filt_r;
  logic [BRIGHT_W-1:0]       b3_bright_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b3_valid_r <= 1'b0;
    end else if (en) begin
      b3_valid_r <= b2_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b3_filt_r   <= filt_nxt;
      b3_bright_r <= b2_bright_r;
    end
  end

  // brightness scale and saturation into the output register
  logic [NUM_CH-1:0][PW-1:0]   lit;
  logic [NUM_CH-1:0][RW-1:0]   lit_int;
  logic [NUM_CH-1:0][CH_W-1:0] chan_nxt;

  always_comb begin
    for (int ch = 0; ch < NUM_CH; ch++) begin
      lit[ch]     = PW'(b3_filt_r[ch]) * PW'(b3_bright_r);
      lit_int[ch] = RW'(lit[ch] >> (F + BRIGHT_FRAC));
      if (lit_int[ch] > RW'({CH_W{1'b1}})) begin
        chan_nxt[ch] = {CH_W{1'b1}};
      end else begin
        chan_nxt[ch] = lit_int[ch][CH_W-1:0];
      end
    end
  end

  logic [OUT_TDATA_W-1:0] out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= b3_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data_r <= {chan_nxt[2], chan_nxt[1], chan_nxt[0]};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

`default_nettype wire

@@ src/bilinear_texture_sampler_unit.sv @@
// ---------------------------------------------------------------------------
// bilinear_texture_sampler_unit - RGB888 bilinear texture sampler
// Texel store with write and sample items; bilinear filter with brightness.
// ---------------------------------------------------------------------------
//  channel   direction  carries
//  in_*      input      write texel or sample item, tuser = op
//  out_*     output     filtered rgb result, one per sample item
//  cfg_*     input      apb register port, texture width and height
//
//  one item per cycle sustained while the output does not stall; a sample
//  result passes the setup register, loaded at the accepting edge, then the
//  queue, store read, two blend stages and brightness scale
//  four store banks, each a full copy, give the four neighbor reads per cycle
//  rst_n clears control state only; store contents are undefined until written
//  an output stall holds the back pipeline; the queue then fills and in_tready
//  drops
// ---------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module bilinear_texture_sampler_unit #(
  parameter int MAX_TEX_WIDTH   = bts_pkg::MAX_TEX_WIDTH_DEF,
  parameter int MAX_TEX_HEIGHT  = bts_pkg::MAX_TEX_HEIGHT_DEF,
  parameter int COORD_FRAC_BITS = bts_pkg::COORD_FRAC_BITS_DEF
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // input item
  input  wire                              in_tvalid,
  output logic                             in_tready,
  // op
  input  wire  [0:0]                       in_tuser,
  // texel_addr, texel_red, texel_green, texel_blue, u_coord, v_coord,
  // brightness, zero fill
  input  wire  [bts_pkg::IN_TDATA_W-1:0]   in_tdata,
  // result item
  output logic                             out_tvalid,
  input  wire                              out_tready,
  // out_red, out_green, out_blue
  output logic [bts_pkg::OUT_TDATA_W-1:0]  out_tdata,
  // configuration
  input  wire                              cfg_psel,
  input  wire                              cfg_penable,
  input  wire                              cfg_pwrite,
  input  wire  [bts_pkg::CFG_AW-1:0]       cfg_paddr,
  input  wire  [bts_pkg::CFG_DW-1:0]       cfg_pwdata,
  output logic [bts_pkg::CFG_DW-1:0]       cfg_prdata,
  output logic                             cfg_pready
);
  import bts_pkg::*;

  localparam int QW = q_width(COORD_FRAC_BITS);

  // configuration registers
  logic [DIM_REG_W-1:0] tex_width_r;
  logic [DIM_REG_W-1:0] tex_height_r;
  logic                 cfg_wr;
  logic                 cfg_sel;
  logic                 cfg_wr_width;

  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_sel      = cfg_paddr[2];
  assign cfg_wr_width = cfg_wr && (cfg_sel == REG_TEX_WIDTH);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tex_width_r  <= DIM_RESET;
      tex_height_r <= DIM_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_TEX_WIDTH:  tex_width_r  <= cfg_pwdata[DIM_REG_W-1:0];
        REG_TEX_HEIGHT: tex_height_r <= cfg_pwdata[DIM_REG_W-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_TEX_WIDTH:  cfg_prdata = CFG_DW'(tex_width_r);
      REG_TEX_HEIGHT: cfg_prdata = CFG_DW'(tex_height_r);
      default:        cfg_prdata = '0;
    endcase
  end

  // front, queue, back
  logic          push_valid;
  logic [QW-1:0] push_data;
  logic          q_valid;
  logic [QW-1:0] q_data;
  logic          q_pop;
  bts_q_stat_t   q_stat;

  bts_front #(
    .MAX_TEX_WIDTH  (MAX_TEX_WIDTH),
    .MAX_TEX_HEIGHT (MAX_TEX_HEIGHT),
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tuser  (in_tuser),
    .in_tdata  (in_tdata),
    .tex_width (tex_width_r),
    .tex_height(tex_height_r),
    .q_full    (q_stat.full),
    .push_valid(push_valid),
    .push_data (push_data)
  );

  bts_queue #(
    .DATA_W(QW),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push_valid),
    .push_data(push_data),
    .pop      (q_pop),
    .pop_valid(q_valid),
    .pop_data (q_data),
    .stat     (q_stat)
  );

  bts_back #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  // checks
  `BTS_ASSERT_IMP(a_q_full_not_empty, q_stat.full, !q_stat.empty)
  `BTS_ASSERT_IMP(a_front_blocked, push_valid && q_stat.full, !in_tready)
  `BTS_ASSERT_NXT(a_width_written, cfg_wr_width, tex_width_r == $past(cfg_pwdata[DIM_REG_W-1:0]))

endmodule

`default_nettype wire
